[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted array priority queue package
// Sizes, request and status codes, and the item and control structures that
// the controller, the datapath and the top level share.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = $clog2(DEPTH);

   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_POP  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_EMPTY     = 2'd2;
   localparam logic [1:0] STAT_OUT_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] push_value;
      logic [3:0]  read_index;
   } spq_request_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [4:0]  entry_count;
      logic        is_empty;
      logic [1:0]  status;
   } spq_response_type;

   typedef struct packed {
      logic exec;
      logic use_held;
      logic latch;
      logic sort_step;
      logic sort_phase;
   } spq_cmd_type;

   typedef struct packed {
      logic needs_sort;
   } spq_status_type;

endpackage

[rtl/core/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted array priority queue controller
// Accepts items, and sequences the re-sort passes that a push needs after the
// order mode has changed, followed by the held push itself.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  spq_status_type stat,
   output spq_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SORT   = 2'd1;
   localparam logic [1:0] ST_INSERT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] pass_ff, pass_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (stat.needs_sort) begin
                  cmd.latch = 1'b1;
                  pass_in   = '0;
                  state_in  = ST_SORT;
               end else begin
                  cmd.exec = 1'b1;
               end
            end
         end
         ST_SORT: begin
            cmd.sort_step  = 1'b1;
            cmd.sort_phase = pass_ff[0];
            pass_in        = pass_ff + IDX_W'(1);
            if (pass_ff == IDX_W'(DEPTH - 1)) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.exec     = 1'b1;
            cmd.use_held = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

[rtl/core/spq_datapath.sv]
// ----------------------------------------------------------------------------
// Sorted array priority queue datapath
// A row of entry cells with parallel compare and shift for inserts, neighbour
// compare and swap for re-sort passes, the count, the mode and the result.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  spq_request_type  req_data,
   input  logic             csr_we,
   input  logic             csr_wdata,
   input  spq_cmd_type      cmd,
   output spq_status_type   stat,
   output logic             rsp_valid,
   output spq_response_type rsp_data
);

   logic [DATA_WIDTH-1:0] entries_ff [DEPTH];
   logic [DATA_WIDTH-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  order_mode_ff;
   logic                  dir_ff, dir_in;
   spq_request_type       held_ff;
   spq_request_type       cur;
   spq_response_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] val;
   logic [DEPTH-1:0]      before_val;
   logic [DEPTH-2:0]      swap;

   function automatic logic goes_before(input logic mode,
                                        input logic [DATA_WIDTH-1:0] a,
                                        input logic [DATA_WIDTH-1:0] b);
      return mode ? (a > b) : (a < b);
   endfunction

   assign cur = cmd.use_held ? held_ff : req_data;
   assign val = DATA_WIDTH'(cur.push_value);

   assign stat.needs_sort = (req_data.req_type == REQ_PUSH) &&
                            (count_ff != CNT_W'(DEPTH)) &&
                            (dir_ff != order_mode_ff) &&
                            (count_ff > CNT_W'(1));

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         before_val[i] = (CNT_W'(i) < count_ff) &&
                         goes_before(order_mode_ff, val, entries_ff[i]);
      end
      for (int k = 0; k < DEPTH - 1; k++) begin
         swap[k] = (1'(k) == cmd.sort_phase) && (CNT_W'(k + 1) < count_ff) &&
                   goes_before(order_mode_ff, entries_ff[k + 1], entries_ff[k]);
      end
   end

   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      dir_in     = dir_ff;
      rsp_in     = '0;
      if (cmd.sort_step) begin
         for (int k = 0; k < DEPTH - 1; k++) begin
            if (swap[k]) begin
               entries_in[k]     = entries_ff[k + 1];
               entries_in[k + 1] = entries_ff[k];
            end
         end
      end
      if (cmd.exec) begin
         unique case (cur.req_type)
            REQ_PUSH: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (before_val[i] || (CNT_W'(i) == count_ff)) begin
                        entries_in[i] = val;
                     end
                  end
                  for (int i = 1; i < DEPTH; i++) begin
                     if (before_val[i - 1]) begin
                        entries_in[i] = entries_ff[i - 1];
                     end
                  end
                  count_in = count_ff + CNT_W'(1);
                  dir_in   = order_mode_ff;
               end
            end
            REQ_POP: begin
               if (count_ff == '0) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            REQ_READ: begin
               if (32'(cur.read_index) < 32'(count_ff)) begin
                  rsp_in.read_data = 32'(entries_ff[IDX_W'(cur.read_index)]);
               end else begin
                  rsp_in.status = STAT_OUT_RANGE;
               end
            end
            default: begin
            end
         endcase
      end
      rsp_in.entry_count = 5'(count_in);
      rsp_in.is_empty    = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         order_mode_ff <= 1'b0;
         dir_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= cmd.exec;
         if (csr_we) begin
            order_mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (cmd.latch) begin
         held_ff <= req_data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/sorted_array_priority_queue.sv]
// ----------------------------------------------------------------------------
// Sorted array priority queue
// Latency: the result strobe comes in the cycle after an item is accepted; a
// push after the order mode has changed first waits DEPTH re-sort passes.
// Throughput: one item per cycle while busy is low, set by the parallel compare
// and shift of the entry row; a re-sorting push holds busy through its passes.
// Synchronous reset clears the count, mode and controller; entries are kept.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue import spq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_request_type  req_data,
   output logic             rsp_valid,
   output spq_response_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   spq_cmd_type    cmd;
   spq_status_type stat;

   spq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   spq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_direct_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !stat.needs_sort) |=> rsp_valid)
      else $error("Accepted item gave no result in the next cycle.");

   a_sorted_push_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("Re-sorting push finished without a result.");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_count == 5'd0)))
      else $error("Empty flag disagrees with the entry count.");

   a_sort_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.sort_step |-> (busy && !rsp_valid))
      else $error("Re-sort pass outside a busy period.");

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Sorted array priority queue testbench
// Drives push, pop, read and unused requests into the queue with random gaps.
// Order mode changes only while the queue is idle, often with entries still
// stored. Every response is checked field by field against a directed row's
// expected fields where it gives them, else against a model of the sorted
// store in this testbench. A short table of directed items covers the empty,
// full and out-of-range cases first. Random phases in both order modes follow.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import spq_pkg::*;

   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         PHASES      = 8;
   localparam int         PHASE_ITEMS = 176;
   localparam int         ROW_COUNT   = 24;

   typedef struct packed {
      logic             set_mode;
      logic             mode;
      logic [1:0]       kind;
      logic [31:0]      value;
      logic [3:0]       index;
      logic [4:0]       reps;
      logic             typed;
      spq_response_type want;
   } stim_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   spq_request_type  req_data  = '0;
   logic             rsp_valid;
   spq_response_type rsp_data;
   logic             csr_we    = 1'b0;
   logic             csr_wdata = 1'b0;

   logic [31:0]      store_entries [DEPTH];
   int unsigned      store_count = 0;
   logic             store_desc  = 1'b0;
   spq_response_type pending_responses [$];
   int               error_count = 0;
   int               cycle_count = 0;
   bit               burst_run   = 1'b0;
   stim_row_type     directed_rows [ROW_COUNT];

   sorted_array_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic spq_response_type apply_request(spq_request_type rq);
      spq_response_type rs;
      logic [31:0]      key;
      int               i;
      int               j;
      rs = '0;
      case (rq.req_type)
         REQ_PUSH: begin
            if (store_count >= DEPTH) begin
               rs.status = STAT_FULL;
            end else begin
               store_entries[store_count] = rq.push_value;
               store_count++;
               for (i = 1; i < store_count; i++) begin
                  key = store_entries[i];
                  j = i;
                  while (j > 0 && (store_desc ? key > store_entries[j - 1]
                                              : key < store_entries[j - 1])) begin
                     store_entries[j] = store_entries[j - 1];
                     j--;
                  end
                  store_entries[j] = key;
               end
            end
         end
         REQ_POP: begin
            if (store_count == 0) rs.status = STAT_EMPTY;
            else store_count--;
         end
         REQ_READ: begin
            if (rq.read_index < store_count) rs.read_data = store_entries[rq.read_index];
            else rs.status = STAT_OUT_RANGE;
         end
         default: ;
      endcase
      rs.entry_count = store_count[4:0];
      rs.is_empty    = (store_count == 0);
      return rs;
   endfunction

   function automatic spq_request_type random_request(int push_pct);
      spq_request_type rq;
      int              sel;
      int              pop_top;
      sel     = $urandom_range(0, 99);
      pop_top = push_pct + (96 - push_pct) / 2;
      rq.req_type   = (sel < push_pct) ? REQ_PUSH : (sel < pop_top) ? REQ_POP :
                      (sel < 96) ? REQ_READ : REQ_UNUSED;
      case ($urandom_range(0, 9))
         0:       rq.push_value = 32'h0;
         1:       rq.push_value = 32'hFFFF_FFFF;
         2, 3, 4: rq.push_value = $urandom_range(0, 15);
         default: rq.push_value = $urandom();
      endcase
      if (rq.req_type == REQ_READ && store_count > 0 && $urandom_range(0, 3) != 0)
         rq.read_index = 4'($urandom_range(0, store_count - 1));
      else
         rq.read_index = 4'($urandom_range(0, 15));
      return rq;
   endfunction

   function automatic stim_row_type item_row(logic [1:0] kind, logic [31:0] value,
                                             logic [3:0] index, int reps);
      stim_row_type r;
      r = '0;
      r.kind  = kind;
      r.value = value;
      r.index = index;
      r.reps  = reps[4:0];
      return r;
   endfunction

   function automatic stim_row_type row_chk(logic [1:0] kind, logic [31:0] value,
                                            logic [3:0] index, logic [31:0] data,
                                            logic [4:0] cnt, logic empty, logic [1:0] stat);
      stim_row_type r;
      r = item_row(kind, value, index, 1);
      r.typed            = 1'b1;
      r.want.read_data   = data;
      r.want.entry_count = cnt;
      r.want.is_empty    = empty;
      r.want.status      = stat;
      return r;
   endfunction

   function automatic stim_row_type mode_row(logic m);
      stim_row_type r;
      r = '0;
      r.set_mode = 1'b1;
      r.mode     = m;
      return r;
   endfunction

   task automatic flag_error(string msg);
      error_count++;
      $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic send_request(spq_request_type rq, logic use_want, spq_response_type want);
      int               gap;
      spq_response_type predicted;
      gap = burst_run ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      predicted = apply_request(rq);
      pending_responses = {pending_responses, (use_want ? want : predicted)};
   endtask

   task automatic set_order(logic m);
      @(negedge clock);
      start <= 1'b0;
      while (pending_responses.size() != 0 || busy) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we    <= 1'b0;
      store_desc = m;
   endtask

   always @(posedge clock) begin
      spq_response_type want;
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            flag_error($sformatf("response with none expected: %h", rsp_data));
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.read_data !== want.read_data)
               flag_error($sformatf("read_data %h, expected %h",
                                    rsp_data.read_data, want.read_data));
            if (rsp_data.entry_count !== want.entry_count)
               flag_error($sformatf("entry_count %0d, expected %0d",
                                    rsp_data.entry_count, want.entry_count));
            if (rsp_data.is_empty !== want.is_empty)
               flag_error($sformatf("is_empty %b, expected %b",
                                    rsp_data.is_empty, want.is_empty));
            if (rsp_data.status !== want.status)
               flag_error($sformatf("status %0d, expected %0d",
                                    rsp_data.status, want.status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout with %0d responses outstanding", pending_responses.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      spq_request_type rq;
      int              push_pct;
      int              n;
      directed_rows = '{
         row_chk(REQ_POP, 32'hFFFF_FFFF, 4'hF, 32'h0, 5'd0, 1'b1, STAT_EMPTY),
         row_chk(REQ_READ, 32'h0, 4'h0, 32'h0, 5'd0, 1'b1, STAT_OUT_RANGE),
         row_chk(REQ_UNUSED, 32'hFFFF_FFFF, 4'hF, 32'h0, 5'd0, 1'b1, STAT_OK),
         row_chk(REQ_PUSH, 32'hFFFF_FFFF, 4'h0, 32'h0, 5'd1, 1'b0, STAT_OK),
         row_chk(REQ_PUSH, 32'h0, 4'hF, 32'h0, 5'd2, 1'b0, STAT_OK),
         row_chk(REQ_READ, 32'h0, 4'h0, 32'h0, 5'd2, 1'b0, STAT_OK),
         row_chk(REQ_READ, 32'h0, 4'h1, 32'hFFFF_FFFF, 5'd2, 1'b0, STAT_OK),
         row_chk(REQ_READ, 32'hFFFF_FFFF, 4'hF, 32'h0, 5'd2, 1'b0, STAT_OUT_RANGE),
         item_row(REQ_PUSH, 32'h8000_0000, 4'h0, 1),
         item_row(REQ_PUSH, 32'h5A5A_5A5A, 4'h0, 13),
         row_chk(REQ_PUSH, 32'h1, 4'h0, 32'h0, 5'd16, 1'b0, STAT_FULL),
         row_chk(REQ_READ, 32'h0, 4'hF, 32'hFFFF_FFFF, 5'd16, 1'b0, STAT_OK),
         item_row(REQ_UNUSED, 32'h0, 4'h0, 1),
         mode_row(1'b1),
         item_row(REQ_READ, 32'h0, 4'h0, 1),
         item_row(REQ_POP, 32'h0, 4'h0, 1),
         item_row(REQ_PUSH, 32'h1234_5678, 4'h0, 1),
         item_row(REQ_READ, 32'h0, 4'h0, 1),
         item_row(REQ_READ, 32'h0, 4'hF, 1),
         item_row(REQ_PUSH, 32'h7, 4'h3, 1),
         mode_row(1'b0),
         item_row(REQ_POP, 32'h0, 4'h0, 1),
         item_row(REQ_PUSH, 32'h0, 4'h0, 1),
         item_row(REQ_READ, 32'h0, 4'h3, 1)
      };
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].set_mode) begin
            set_order(directed_rows[r].mode);
         end else begin
            rq.req_type   = directed_rows[r].kind;
            rq.push_value = directed_rows[r].value;
            rq.read_index = directed_rows[r].index;
            for (n = 0; n < directed_rows[r].reps; n++)
               send_request(rq, directed_rows[r].typed, directed_rows[r].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         set_order(p[0] ^ 1'b1);
         push_pct = $urandom_range(30, 65);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 25 == 0) burst_run = ($urandom_range(0, 3) == 0);
            send_request(random_request(push_pct), 1'b0, '0);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
